@@ src/adc_average_calibrate_unit_macros.svh @@
// Assertion macros shared by the averaging calibration unit.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ADC_AVERAGE_CALIBRATE_UNIT_MACROS_SVH
`define ADC_AVERAGE_CALIBRATE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds on every clock edge outside reset
`define AVC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that an expression is never true outside reset
`define AVC_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define AVC_ASSERT(label, clk, rst_n, prop, msg)
`define AVC_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

@@ src/avc_pkg.sv @@
// Package for the averaging calibration unit: constants, command/status types,
// and the byte clamp helper. No dependencies.
`timescale 1ns / 1ps

package avc_pkg;

    // Default parameter values
    localparam int SAMPLE_BITS_DEF      = 12;
    localparam int AVERAGE_LOG2_DEF     = 10;
    localparam int CHANNELS_DEF         = 8;
    localparam int BIPOLAR_CHANNELS_DEF = 2;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSETS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAINS   = 2'd1;

    // Result fields
    localparam int OUT_CH_W   = 3;
    localparam int VOLT_W     = 22;
    localparam int VOLT_LIMIT = 1200000;

    // Mean is always 16 bits wide
    localparam int MEAN_W = 16;

    // Scaled mean: A = m*K - Z - ofs*65536 (all divided down by 100)
    localparam int K_W         = 16;
    localparam int K_BIPOLAR   = 20000;
    localparam int K_UNIPOLAR  = 10000;
    localparam int Z_BIPOLAR   = 655360000;
    localparam int OFS_SHIFT   = 16;
    localparam int MK_W        = MEAN_W + K_W + 1;
    localparam int A_W         = 34;

    // Gain factor 1000 + g
    localparam int GF_W      = 12;
    localparam int GAIN_UNIT = 1000;
    localparam int P_W       = A_W + GF_W;

    // Rounded divide by 655360 = 5 * 2^17
    localparam int ROUND_HALF  = 327680;
    localparam int ROUND_SHIFT = 17;
    localparam int Y_W         = P_W - ROUND_SHIFT;
    localparam int DIV5        = 5;
    localparam int RECIP_SHIFT = 29;
    localparam int RECIP_W     = 27;
    localparam int RECIP_MUL   = (1 << RECIP_SHIFT) / DIV5;
    localparam int QP_W        = Y_W + RECIP_W;
    localparam int Q_W         = QP_W - RECIP_SHIFT;

    // Clamp bound for offset and gain bytes
    localparam int BYTE_LIMIT = 100;
    localparam int LANES      = 8;

    typedef struct packed {
        logic add;      // sample transfer: accumulate
        logic finish;   // last sample of the block: latch mean, restart
        logic ld_a;     // scaled, offset-corrected mean
        logic ld_p;     // gain product
        logic ld_y;     // rounded magnitude over 2^17
        logic ld_q;     // reciprocal quotient estimate
        logic ld_out;   // corrected, saturated result to output register
    } cmd_t;

    typedef struct packed {
        logic last;     // next sample completes the block
    } status_t;

    // Pick byte idx of a register, treat as signed, clamp to +-100; idx 8..15 gives 0
    function automatic logic signed [7:0] byte_clamp(input logic [63:0] r,
                                                     input logic [3:0] idx);
        logic signed [7:0] v;
        v = r[idx[2:0]*8 +: 8];
        if (idx[3])
            v = 8'sd0;
        else if (v > 8'(BYTE_LIMIT))
            v = 8'(BYTE_LIMIT);
        else if (v < -8'(BYTE_LIMIT))
            v = -8'(BYTE_LIMIT);
        return v;
    endfunction

endpackage

@@ src/avc_ctrl.sv @@
// Controller for the averaging calibration unit: sample handshake, the
// calibration step sequence and the result valid flag. Uses avc_pkg.
`timescale 1ns / 1ps
`include "adc_average_calibrate_unit_macros.svh"

module avc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  avc_pkg::status_t status,
    output avc_pkg::cmd_t    cmd
);
    import avc_pkg::*;

    localparam logic [2:0] ST_ACCUM = 3'd0;
    localparam logic [2:0] ST_CAL_A = 3'd1;
    localparam logic [2:0] ST_CAL_P = 3'd2;
    localparam logic [2:0] ST_CAL_Y = 3'd3;
    localparam logic [2:0] ST_CAL_Q = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       in_xfer;

    // Hold the last sample back while the previous result is still waiting
    assign in_ready = (state_reg == ST_ACCUM) && !(status.last && out_valid_reg);
    assign in_xfer  = in_valid && in_ready;

    // Decode commands from state
    always_comb
    begin
        cmd        = '0;
        cmd.add    = in_xfer;
        cmd.finish = in_xfer && status.last;
        cmd.ld_a   = (state_reg == ST_CAL_A);
        cmd.ld_p   = (state_reg == ST_CAL_P);
        cmd.ld_y   = (state_reg == ST_CAL_Y);
        cmd.ld_q   = (state_reg == ST_CAL_Q);
        cmd.ld_out = (state_reg == ST_OUT);
    end

    // Advance through the calibration steps
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ACCUM: if (in_xfer && status.last) state_next = ST_CAL_A;
            ST_CAL_A: state_next = ST_CAL_P;
            ST_CAL_P: state_next = ST_CAL_Y;
            ST_CAL_Y: state_next = ST_CAL_Q;
            ST_CAL_Q: state_next = ST_OUT;
            ST_OUT:   state_next = ST_ACCUM;
            default:  state_next = ST_ACCUM;
        endcase
    end

    // Set on result load, drop on output transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (state_reg == ST_OUT)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `AVC_ASSERT(a_finish_starts_cal, clk, rst_n, cmd.finish |=> cmd.ld_a, "no calibration start")
    `AVC_NEVER(a_finish_while_full, clk, rst_n, cmd.finish && out_valid_reg, "finish while full")
    `AVC_NEVER(a_cal_while_full, clk, rst_n, cmd.ld_a && out_valid_reg, "calibration while full")
    `AVC_ASSERT(a_load_sets_valid, clk, rst_n, cmd.ld_out |=> out_valid_reg, "valid not raised")

endmodule

@@ src/avc_datapath.sv @@
// Datapath for the averaging calibration unit: accumulator, channel counter,
// configuration registers and the staged calibration arithmetic. Uses avc_pkg.
`timescale 1ns / 1ps

module avc_datapath #(
    parameter int SAMPLE_BITS      = avc_pkg::SAMPLE_BITS_DEF,
    parameter int AVERAGE_LOG2     = avc_pkg::AVERAGE_LOG2_DEF,
    parameter int CHANNELS         = avc_pkg::CHANNELS_DEF,
    parameter int BIPOLAR_CHANNELS = avc_pkg::BIPOLAR_CHANNELS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [avc_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [avc_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic [SAMPLE_BITS-1:0]                sample,
    input  avc_pkg::cmd_t                         cmd,
    output avc_pkg::status_t                      status,
    output logic [avc_pkg::OUT_CH_W-1:0]          channel,
    output logic signed [avc_pkg::VOLT_W-1:0]     voltage
);
    import avc_pkg::*;

    localparam int ACC_W      = SAMPLE_BITS + AVERAGE_LOG2;
    localparam int MEAN_SHIFT = ACC_W - MEAN_W;
    localparam int RSH        = (MEAN_SHIFT > 0) ? MEAN_SHIFT : 0;
    localparam int LSH        = (MEAN_SHIFT < 0) ? -MEAN_SHIFT : 0;
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [CFG_DATA_W-1:0]   offsets_reg, gains_reg;
    logic [ACC_W-1:0]        acc_reg, acc_sum;
    logic [AVERAGE_LOG2-1:0] cnt_reg;
    logic [CH_W-1:0]         ch_reg, ch_calc_reg;

    logic [MEAN_W-1:0]       mean_reg, mean_next;
    logic                    bip_reg;
    logic signed [7:0]       ofs_reg;
    logic signed [GF_W-1:0]  gf_reg, gf_next;

    logic signed [MEAN_W:0]  m_s;
    logic signed [K_W-1:0]   k_s;
    logic signed [MK_W-1:0]  mk;
    logic signed [A_W-1:0]   a_reg, a_next;
    logic signed [P_W-1:0]   p_reg, p_next;
    logic [P_W-1:0]          p_mag;
    logic [Y_W-1:0]          y_reg, y_next;
    logic                    neg_reg;
    logic [QP_W-1:0]         qp;
    logic [Q_W-1:0]          q0_reg, q0_next;
    logic [Y_W-1:0]          rem;
    logic [Q_W-1:0]          q;
    logic [VOLT_W-1:0]       q_sat;
    logic [OUT_CH_W-1:0]     ch_out_reg;
    logic signed [VOLT_W-1:0] volt_out_reg, volt_next;

    // Write configuration registers; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offsets_reg <= '0;
            gains_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_OFFSETS: offsets_reg <= cfg_data;
                CFG_GAINS:   gains_reg   <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Accumulate samples, count the block, advance the channel at block end
    assign acc_sum     = acc_reg + ACC_W'(sample);
    assign status.last = &cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
            ch_reg  <= '0;
        end
        else if (cmd.add)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cmd.finish)
            begin
                acc_reg <= '0;
                if (ch_reg == CH_W'(CHANNELS - 1))
                    ch_reg <= '0;
                else
                    ch_reg <= ch_reg + 1'b1;
            end
            else
            begin
                acc_reg <= acc_sum;
            end
        end
    end

    // Scale the block sum to a 16-bit mean; pick channel calibration
    assign mean_next = MEAN_W'((32'(acc_sum) << LSH) >> RSH);
    assign gf_next   = GF_W'(GAIN_UNIT) + GF_W'(byte_clamp(gains_reg, 4'(ch_reg)));

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            mean_reg    <= mean_next;
            ch_calc_reg <= ch_reg;
            bip_reg     <= (32'(ch_reg) < 32'(BIPOLAR_CHANNELS));
            ofs_reg     <= byte_clamp(offsets_reg, 4'(ch_reg));
            gf_reg      <= gf_next;
        end
    end

    // Step A: mean times full scale, minus bipolar zero and offset
    assign m_s    = $signed({1'b0, mean_reg});
    assign k_s    = bip_reg ? K_W'(K_BIPOLAR) : K_W'(K_UNIPOLAR);
    assign mk     = m_s * k_s;
    assign a_next = A_W'(mk) - (bip_reg ? A_W'(Z_BIPOLAR) : A_W'(0))
                    - (A_W'(ofs_reg) <<< OFS_SHIFT);

    // Step P: apply gain
    assign p_next = a_reg * gf_reg;

    // Step Y: magnitude, add half, drop the power-of-two part of the divisor
    assign p_mag  = p_reg[P_W-1] ? P_W'(-p_reg) : P_W'(p_reg);
    assign y_next = Y_W'((p_mag + P_W'(ROUND_HALF)) >> ROUND_SHIFT);

    // Step Q: divide by five through the reciprocal, low by at most one
    assign qp      = QP_W'(y_reg) * QP_W'(RECIP_MUL);
    assign q0_next = Q_W'(qp >> RECIP_SHIFT);

    // Step out: correct the quotient, restore sign, saturate
    assign rem   = y_reg - (Y_W'({q0_reg, 2'b00}) + Y_W'(q0_reg));
    assign q     = q0_reg + Q_W'(rem >= Y_W'(DIV5));
    assign q_sat = (q > Q_W'(VOLT_LIMIT)) ? VOLT_W'(VOLT_LIMIT) : VOLT_W'(q);
    assign volt_next = neg_reg ? -$signed(q_sat) : $signed(q_sat);

    always_ff @(posedge clk)
    begin
        if (cmd.ld_a)
            a_reg <= a_next;
        if (cmd.ld_p)
            p_reg <= p_next;
        if (cmd.ld_y)
        begin
            y_reg   <= y_next;
            neg_reg <= p_reg[P_W-1];
        end
        if (cmd.ld_q)
            q0_reg <= q0_next;
        if (cmd.ld_out)
        begin
            ch_out_reg   <= OUT_CH_W'(ch_calc_reg);
            volt_out_reg <= volt_next;
        end
    end

    assign channel = ch_out_reg;
    assign voltage = volt_out_reg;

endmodule

@@ src/adc_average_calibrate_unit.sv @@
// Top level of the ADC averaging and calibration unit.
// Joins avc_ctrl and avc_datapath; uses avc_pkg.
`timescale 1ns / 1ps

// Usage:
//   Samples arrive on the in_valid/in_ready/sample channel, one conversion
//   per transfer, for the current channel of a round-robin over CHANNELS.
//   After 2^AVERAGE_LOG2 transfers the block mean is calibrated and one
//   result (channel, voltage in 10 uV units) leaves on the
//   out_valid/out_ready channel.
//   Throughput: one sample per cycle while a block fills; the five-step
//   calibration sequencer (scale, gain multiply, round, reciprocal divide,
//   correct) holds in_ready low after the last sample of each block until
//   the result, passed through the a, p, y and q0 registers, loads into the
//   output register; out_valid rises with that load.
//   A result stays in the output register until taken; samples keep being
//   accepted meanwhile, but the last sample of the next block is held back
//   until the previous result has been transferred.
//   Configuration: cfg_write with cfg_index 0 (offsets) or 1 (gains) loads
//   the 64-bit cfg_data; other indexes are dropped. Write only
//   while idle.
//   Reset clears the accumulator, sample count, channel, both configuration
//   registers (no offset, unity gain) and the output valid flag.
module adc_average_calibrate_unit #(
    parameter int SAMPLE_BITS      = avc_pkg::SAMPLE_BITS_DEF,
    parameter int AVERAGE_LOG2     = avc_pkg::AVERAGE_LOG2_DEF,
    parameter int CHANNELS         = avc_pkg::CHANNELS_DEF,
    parameter int BIPOLAR_CHANNELS = avc_pkg::BIPOLAR_CHANNELS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [avc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [avc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [SAMPLE_BITS-1:0]            sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [avc_pkg::OUT_CH_W-1:0]      channel,
    output logic signed [avc_pkg::VOLT_W-1:0] voltage
);
    import avc_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequence the handshake and calibration steps
    avc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Accumulate and calibrate
    avc_datapath #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .AVERAGE_LOG2     (AVERAGE_LOG2),
        .CHANNELS         (CHANNELS),
        .BIPOLAR_CHANNELS (BIPOLAR_CHANNELS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .cmd       (cmd),
        .status    (status),
        .channel   (channel),
        .voltage   (voltage)
    );

endmodule
